// ===== rtl/core/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

    // action codes of an input beat
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    localparam int URG_W   = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 4;

    // one job slot as stored in the slot memory
    typedef struct packed {
        logic [URG_W-1:0]   urgency;
        logic [BURST_W-1:0] remaining;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  stamp;
    } t_slot;

    // sequencer controls for the compare unit
    typedef struct packed {
        logic clear;     // start of a new scan
        logic step;      // slot data on the read port is to be judged
        logic eligible;  // that slot is valid and not the running job
        logic is_cur;    // that slot holds the running job
    } t_pick_ctl;

endpackage

// ===== rtl/core/pps_slot_mem.sv =====
`timescale 1ns / 1ps

module pps_slot_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  pps_pkg::t_slot  i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output pps_pkg::t_slot  o_rdata
);
    import pps_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pps_pick.sv =====
`timescale 1ns / 1ps

module pps_pick #(
    parameter int IW = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pps_pkg::t_pick_ctl       i_ctl,
    input  logic [IW-1:0]            i_idx,
    input  logic [pps_pkg::URG_W-1:0] i_urg,
    output logic                     o_found,
    output logic [IW-1:0]            o_best_idx,
    output logic [pps_pkg::URG_W-1:0] o_best_urg,
    output logic [pps_pkg::URG_W-1:0] o_cur_urg
);
    import pps_pkg::*;

    logic            r_found;
    logic [IW-1:0]   r_best_idx;
    logic [URG_W-1:0] r_best_urg;
    logic [URG_W-1:0] r_cur_urg;
    logic            w_take;

    // strict compare keeps the lowest id on ties (slots come in ascending order)
    assign w_take = i_ctl.step && i_ctl.eligible && (!r_found || (i_urg > r_best_urg));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    // best candidate and urgency of the running job
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_best_idx <= i_idx;
            r_best_urg <= i_urg;
        end
        if (i_ctl.step && i_ctl.is_cur) begin
            r_cur_urg <= i_urg;
        end
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;
    assign o_best_urg = r_best_urg;
    assign o_cur_urg  = r_cur_urg;

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Arrive beat: result strobe in the cycle after acceptance; busy never rises.
// Tick beat: busy through the scan, pick, read, exec and fin states; the slot scan
//   reads one slot a cycle through the single read port of the slot memory.
// The result strobe comes in the first cycle that busy is low again.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset (synchronous, active low) empties all slots, stops the running job, zeroes time.
`timescale 1ns / 1ps

module preemptive_priority_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [pps_pkg::ID_W-1:0]    i_job_id,
    input  logic [pps_pkg::BURST_W-1:0] i_burst,
    input  logic [pps_pkg::URG_W-1:0]   i_urgency,
    output logic                        o_strobe,
    output logic                        o_accepted,
    output logic                        o_busy_res,
    output logic [pps_pkg::ID_W-1:0]    o_running_job,
    output logic                        o_switched,
    output logic                        o_done_res,
    output logic [pps_pkg::TIME_W-1:0]  o_finish_time,
    output logic [pps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]  o_waiting,
    output logic [pps_pkg::TIME_W-1:0]  o_now_time
);
    import pps_pkg::*;

    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_PICK = 6'b000100,
        ST_READ = 6'b001000,
        ST_EXEC = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_idx;
    logic [IW-1:0]       r_cur;
    logic                r_running;
    logic [TIME_W-1:0]   r_time;
    logic [MAX_JOBS-1:0] r_valid;
    logic [BURST_W-1:0]  r_burst;

    logic                r_strobe;
    logic                r_accepted;
    logic                r_busy_res;
    logic [ID_W-1:0]     r_job;
    logic                r_switched;
    logic                r_done;
    logic [TIME_W-1:0]   r_finish;
    logic [TIME_W-1:0]   r_tat;
    logic [TIME_W-1:0]   r_waiting;
    logic [TIME_W-1:0]   r_now;

    logic [TIME_W-1:0]   n_time;
    logic                w_accept;
    logic [IW-1:0]       w_arr_idx;
    logic                w_arr_ok;
    logic                w_scan_end;
    logic [CW-1:0]       w_prev;
    logic [IW-1:0]       w_proc;
    logic                w_finish;

    logic                w_we;
    logic [IW-1:0]       w_waddr;
    logic [IW-1:0]       w_raddr;
    t_slot               w_wdata;
    t_slot               w_rdata;

    t_pick_ctl           w_ctl;
    logic                w_found;
    logic [IW-1:0]       w_best_idx;
    logic [URG_W-1:0]    w_best_urg;
    logic [URG_W-1:0]    w_cur_urg;

    // handshake and arrival checks
    assign busy      = (r_state != ST_IDLE);
    assign w_accept  = start && !busy;
    assign w_arr_idx = IW'(i_job_id);
    assign w_arr_ok  = (32'(i_job_id) < MAX_JOBS) && !r_valid[w_arr_idx];
    assign n_time    = r_time + TIME_W'(1);

    // scan pointer: address r_idx goes out, data of r_idx-1 comes back
    assign w_scan_end = (r_idx == CW'(MAX_JOBS));
    assign w_prev     = r_idx - CW'(1);
    assign w_proc     = w_prev[IW-1:0];

    assign w_finish = r_running && (w_rdata.remaining <= BURST_W'(1));

    // compare unit controls
    always_comb begin
        w_ctl.clear    = w_accept && (i_action == ACT_TICK);
        w_ctl.step     = (r_state == ST_SCAN) && (r_idx != '0);
        w_ctl.eligible = r_valid[w_proc] && !(r_running && (w_proc == r_cur));
        w_ctl.is_cur   = (w_proc == r_cur);
    end

    // slot memory ports
    always_comb begin
        w_raddr = r_cur;
        if ((r_state == ST_SCAN) && !w_scan_end) begin
            w_raddr = r_idx[IW-1:0];
        end
        w_we    = 1'b0;
        w_waddr = w_arr_idx;
        w_wdata = '{urgency: i_urgency, remaining: i_burst, burst: i_burst, stamp: r_time};
        if (r_state == ST_EXEC) begin
            w_we    = r_running;
            w_waddr = r_cur;
            w_wdata = w_rdata;
            w_wdata.remaining = w_finish ? '0 : (w_rdata.remaining - BURST_W'(1));
        end else if (w_accept && (i_action == ACT_ARRIVE)) begin
            w_we = w_arr_ok;
        end
    end

    pps_slot_mem #(
        .DEPTH (MAX_JOBS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pps_pick #(
        .IW (IW)
    ) u_pick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (w_proc),
        .i_urg      (w_rdata.urgency),
        .o_found    (w_found),
        .o_best_idx (w_best_idx),
        .o_best_urg (w_best_urg),
        .o_cur_urg  (w_cur_urg)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_running <= 1'b0;
            r_cur     <= '0;
            r_time    <= '0;
            r_valid   <= '0;
            r_strobe  <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (i_action == ACT_ARRIVE) begin
                            if (w_arr_ok) begin
                                r_valid[w_arr_idx] <= 1'b1;
                            end
                            r_accepted <= w_arr_ok;
                            r_busy_res <= 1'b0;
                            r_job      <= '0;
                            r_switched <= 1'b0;
                            r_done     <= 1'b0;
                            r_finish   <= '0;
                            r_tat      <= '0;
                            r_waiting  <= '0;
                            r_now      <= r_time;
                            r_strobe   <= 1'b1;
                        end else begin
                            r_idx   <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= ST_PICK;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_PICK: begin
                    // preempt only on strictly higher urgency
                    r_switched <= 1'b0;
                    if (r_running) begin
                        if (w_found && (w_best_urg > w_cur_urg)) begin
                            r_cur      <= w_best_idx;
                            r_switched <= 1'b1;
                        end
                    end else if (w_found) begin
                        r_cur      <= w_best_idx;
                        r_running  <= 1'b1;
                        r_switched <= 1'b1;
                    end
                    r_state <= ST_READ;
                end
                ST_READ: begin
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    // run one time unit
                    r_time     <= n_time;
                    r_now      <= n_time;
                    r_accepted <= 1'b0;
                    r_busy_res <= r_running;
                    r_job      <= r_running ? ID_W'(r_cur) : '0;
                    r_done     <= w_finish;
                    if (w_finish) begin
                        r_valid[r_cur] <= 1'b0;
                        r_running      <= 1'b0;
                        r_finish       <= n_time;
                        r_tat          <= n_time - w_rdata.stamp;
                        r_burst        <= w_rdata.burst;
                    end else begin
                        r_finish <= '0;
                        r_tat    <= '0;
                        r_burst  <= '0;
                    end
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    r_waiting <= r_tat - TIME_W'(r_burst);
                    r_strobe  <= 1'b1;
                    r_state   <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_accepted    = r_accepted;
    assign o_busy_res    = r_busy_res;
    assign o_running_job = r_job;
    assign o_switched    = r_switched;
    assign o_done_res    = r_done;
    assign o_finish_time = r_finish;
    assign o_turnaround  = r_tat;
    assign o_waiting     = r_waiting;
    assign o_now_time    = r_now;

    // results only come out once the sequencer is back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while sequencer busy");

    // an arrival result never reports a run
    a_arrive_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_accepted) |-> (!o_busy_res && !o_done_res && !o_switched))
        else $error("arrival result carries tick fields");

    // a completion needs a job that ran
    a_done_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_done_res) |-> o_busy_res)
        else $error("completion without a running job");

    // a tick beat always occupies the sequencer
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_TICK)) |=> busy)
        else $error("tick beat did not start a scan");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pps_pkg::*;

    localparam int MAX_JOBS    = 16;
    localparam int SCAN_CYCLES = MAX_JOBS + 5;
    localparam int RANDOM_BEATS = 1650;

    // one result beat as seen on the output ports
    typedef struct packed {
        logic              accepted;
        logic              busy_res;
        logic [ID_W-1:0]   running_job;
        logic              switched;
        logic              done_res;
        logic [TIME_W-1:0] finish_time;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] now_time;
    } t_report;

    // shadow copy of the job table; predicts one report per accepted beat
    class sched_shadow;
        bit                 job_live  [MAX_JOBS];
        bit [URG_W-1:0]     job_urg   [MAX_JOBS];
        bit [BURST_W-1:0]   job_left  [MAX_JOBS];
        bit [BURST_W-1:0]   job_burst [MAX_JOBS];
        bit [TIME_W-1:0]    job_stamp [MAX_JOBS];
        int                 run_id;
        bit                 cpu_busy;
        bit [TIME_W-1:0]    clock_now;
        t_report            due_reports[$];
        int                 mismatches;

        // most urgent live job other than skip, lowest id on ties
        function int most_urgent(int skip);
            int best;
            best = -1;
            for (int i = 0; i < MAX_JOBS; i++) begin
                if (job_live[i] && i != skip) begin
                    if (best < 0 || job_urg[i] > job_urg[best]) begin
                        best = i;
                    end
                end
            end
            return best;
        endfunction

        function void accept_beat(logic act, logic [ID_W-1:0] id,
                                  logic [BURST_W-1:0] blen, logic [URG_W-1:0] urg);
            t_report r;
            int      best;
            r = '0;
            if (act == ACT_ARRIVE) begin
                if (id < MAX_JOBS && !job_live[id]) begin
                    job_live[id]  = 1'b1;
                    job_urg[id]   = urg;
                    job_left[id]  = blen;
                    job_burst[id] = blen;
                    job_stamp[id] = clock_now;
                    r.accepted    = 1'b1;
                end
                r.now_time = clock_now;
            end else begin
                // preemption needs strictly higher urgency; idle cpu dispatches
                if (cpu_busy) begin
                    best = most_urgent(run_id);
                    if (best >= 0 && job_urg[best] > job_urg[run_id]) begin
                        run_id     = best;
                        r.switched = 1'b1;
                    end
                end else begin
                    best = most_urgent(-1);
                    if (best >= 0) begin
                        run_id     = best;
                        cpu_busy   = 1'b1;
                        r.switched = 1'b1;
                    end
                end
                clock_now++;
                if (cpu_busy) begin
                    r.busy_res    = 1'b1;
                    r.running_job = run_id[ID_W-1:0];
                    // zero burst still takes one tick
                    if (job_left[run_id] <= 1) begin
                        job_left[run_id] = '0;
                        job_live[run_id] = 1'b0;
                        cpu_busy         = 1'b0;
                        r.done_res       = 1'b1;
                        r.finish_time    = clock_now;
                        r.turnaround     = clock_now - job_stamp[run_id];
                        r.waiting        = r.turnaround - TIME_W'(job_burst[run_id]);
                    end else begin
                        job_left[run_id]--;
                    end
                end
                r.now_time = clock_now;
            end
            due_reports = {due_reports, r};
        endfunction

        function string fields(t_report r);
            return {$sformatf("acc=%0d run=%0d job=%0d sw=%0d done=%0d",
                              r.accepted, r.busy_res, r.running_job, r.switched,
                              r.done_res),
                    $sformatf(" fin=%0d tat=%0d wait=%0d now=%0d",
                              r.finish_time, r.turnaround, r.waiting, r.now_time)};
        endfunction

        function void compare_report(t_report got);
            t_report exp;
            if (due_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected report: %s", fields(got));
                end
            end else begin
                exp = due_reports.pop_front();
                if (got !== exp) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("report mismatch at %0t", $realtime);
                        $display("  expected %s", fields(exp));
                        $display("  actual   %s", fields(got));
                    end
                end
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_action;
    logic [ID_W-1:0]     i_job_id;
    logic [BURST_W-1:0]  i_burst;
    logic [URG_W-1:0]    i_urgency;
    logic                o_strobe;
    logic                o_accepted;
    logic                o_busy_res;
    logic [ID_W-1:0]     o_running_job;
    logic                o_switched;
    logic                o_done_res;
    logic [TIME_W-1:0]   o_finish_time;
    logic [TIME_W-1:0]   o_turnaround;
    logic [TIME_W-1:0]   o_waiting;
    logic [TIME_W-1:0]   o_now_time;

    sched_shadow shadow;

    preemptive_priority_scheduler #(
        .MAX_JOBS(MAX_JOBS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_job_id(i_job_id),
        .i_burst(i_burst),
        .i_urgency(i_urgency),
        .o_strobe(o_strobe),
        .o_accepted(o_accepted),
        .o_busy_res(o_busy_res),
        .o_running_job(o_running_job),
        .o_switched(o_switched),
        .o_done_res(o_done_res),
        .o_finish_time(o_finish_time),
        .o_turnaround(o_turnaround),
        .o_waiting(o_waiting),
        .o_now_time(o_now_time)
    );

    always #5 i_clk = ~i_clk;

    // present one beat and hold it until the block takes it
    task automatic send_beat(input logic act, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] blen, input logic [URG_W-1:0] urg);
        i_action  <= act;
        i_job_id  <= id;
        i_burst   <= blen;
        i_urgency <= urg;
        start     <= 1'b1;
        do @(posedge i_clk); while (busy);
        shadow.accept_beat(act, id, blen, urg);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // result monitor: every strobe is one report beat
    always @(posedge i_clk) begin
        t_report seen;
        if (i_rst_n && o_strobe) begin
            seen = '{o_accepted, o_busy_res, o_running_job, o_switched, o_done_res,
                     o_finish_time, o_turnaround, o_waiting, o_now_time};
            shadow.compare_report(seen);
        end
    end

    initial begin
        int                 sent;
        int                 run_len;
        int                 gap_mode;
        int                 big_left;
        int                 pick;
        logic               act;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] blen;
        logic [URG_W-1:0]   urg;

        shadow = new;
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_action  <= ACT_TICK;
        i_job_id  <= '0;
        i_burst   <= '0;
        i_urgency <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle tick, zero burst, occupied slots, ties, preemption
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_ARRIVE, 4'd0,  16'd0,     8'd5);
        send_beat(ACT_ARRIVE, 4'd0,  16'd9,     8'd9);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_ARRIVE, 4'd15, 16'hFFFF,  8'd0);
        send_beat(ACT_ARRIVE, 4'd7,  16'd2,     8'd100);
        send_beat(ACT_ARRIVE, 4'd5,  16'd1,     8'd100);
        send_beat(ACT_TICK,   4'd15, 16'hFFFF,  8'hFF);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_ARRIVE, 4'd2,  16'd1,     8'd100);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_ARRIVE, 4'd9,  16'd3,     8'd200);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_ARRIVE, 4'd9,  16'd1,     8'd1);
        send_beat(ACT_ARRIVE, 4'd10, 16'd1,     8'd255);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_ARRIVE, 4'd15, 16'd0,     8'd255);
        send_beat(ACT_ARRIVE, 4'd3,  16'd0,     8'hFF);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);
        send_beat(ACT_TICK,   4'd0,  16'd0,     8'd0);

        // random bursts of beats; long jobs kept rare so slots keep turning over
        sent     = 0;
        big_left = 3;
        while (sent < RANDOM_BEATS) begin
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
                id   = ID_W'($urandom_range(0, MAX_JOBS - 1));
                blen = BURST_W'($urandom_range(0, 65535));
                urg  = URG_W'($urandom_range(0, 255));
                if ($urandom_range(0, 99) < 45) begin
                    act  = ACT_ARRIVE;
                    pick = $urandom_range(0, 99);
                    if (big_left > 0 && pick == 0) begin
                        big_left--;
                        urg = '0;
                    end else if (pick < 70) begin
                        blen = BURST_W'($urandom_range(0, 3));
                    end else begin
                        blen = BURST_W'($urandom_range(4, 12));
                    end
                    if (big_left >= 0 && blen > 12) begin
                        // long job: lowest urgency
                    end else begin
                        pick = $urandom_range(0, 99);
                        if (pick < 3) begin
                            urg = '0;
                        end else if (pick < 40) begin
                            urg = URG_W'($urandom_range(1, 3));
                        end else begin
                            urg = URG_W'($urandom_range(1, 255));
                        end
                    end
                end else begin
                    act = ACT_TICK;
                end
                send_beat(act, id, blen, urg);
                sent++;
            end
            gap_mode = $urandom_range(0, 9);
            if (gap_mode < 3) begin
                idle_gap(0);
            end else if (gap_mode < 8) begin
                idle_gap($urandom_range(1, 4));
            end else begin
                idle_gap($urandom_range(5, SCAN_CYCLES + 8));
            end
        end
        start <= 1'b0;

        // drain, then give a stray report time to show up
        while (shadow.due_reports.size() != 0) @(posedge i_clk);
        repeat (SCAN_CYCLES + 4) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.due_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
